@@ rtl/calendar_julian_day_convert_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Julian day converter
// Shared property wrappers clocked on aclk with the synchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_JULIAN_DAY_CONVERT_ASSERT_SVH
`define CALENDAR_JULIAN_DAY_CONVERT_ASSERT_SVH

// same-cycle implication
`define CJDC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CJDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cjdc_pkg.sv @@
// ----------------------------------------------------------------------------
// cjdc_pkg
// Field widths, command codes, calendar constants and month tables.
// ----------------------------------------------------------------------------
package cjdc_pkg;

    // field widths
    localparam int JD_W    = 57;
    localparam int YEAR_W  = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TIME_W  = 32;

    // commands
    localparam logic CMD_TO_JD   = 1'b0;
    localparam logic CMD_TO_DATE = 1'b1;

    // calendar constants
    localparam int YEAR_BASE       = 4712;
    localparam int YEAR_OFFSET     = 4800;
    localparam int DAY_EPOCH       = 32082;
    localparam int GREG_SWITCH_DAY = 1830692;
    localparam int CENTURY_DAYS    = 36525;
    localparam int CENTURY_BIAS    = 38;
    localparam int MONTH_MARCH     = 3;
    localparam int DIV100_MULT     = 41944;   // ceil(2^22 / 100)
    localparam int DIV100_SHIFT    = 22;

    // day-of-year working width and month index limit
    localparam int R_W    = 10;
    localparam int N4_W   = 5;
    localparam int N4_MAX = 16;

    // days before a month, counted from March: floor(30.6 * (m + 1)),
    // with months below March taken as months 12 to 14
    function automatic logic [8:0] month_days_before(input logic [3:0] m);
        logic [8:0] days;
        unique case (m)
            4'd0:  days = 9'd397;
            4'd1:  days = 9'd428;
            4'd2:  days = 9'd459;
            4'd3:  days = 9'd122;
            4'd4:  days = 9'd153;
            4'd5:  days = 9'd183;
            4'd6:  days = 9'd214;
            4'd7:  days = 9'd244;
            4'd8:  days = 9'd275;
            4'd9:  days = 9'd306;
            4'd10: days = 9'd336;
            4'd11: days = 9'd367;
            4'd12: days = 9'd397;
            4'd13: days = 9'd428;
            4'd14: days = 9'd459;
            4'd15: days = 9'd489;
        endcase
        return days;
    endfunction

    // floor(30.6001 * n)
    function automatic logic [9:0] month_start_floor(input logic [4:0] n);
        logic [9:0] days;
        unique case (n)
            5'd0:  days = 10'd0;
            5'd1:  days = 10'd30;
            5'd2:  days = 10'd61;
            5'd3:  days = 10'd91;
            5'd4:  days = 10'd122;
            5'd5:  days = 10'd153;
            5'd6:  days = 10'd183;
            5'd7:  days = 10'd214;
            5'd8:  days = 10'd244;
            5'd9:  days = 10'd275;
            5'd10: days = 10'd306;
            5'd11: days = 10'd336;
            5'd12: days = 10'd367;
            5'd13: days = 10'd397;
            5'd14: days = 10'd428;
            5'd15: days = 10'd459;
            5'd16: days = 10'd489;
            5'd17: days = 10'd520;
            5'd18: days = 10'd550;
            5'd19: days = 10'd581;
            5'd20: days = 10'd612;
            5'd21: days = 10'd642;
            5'd22: days = 10'd673;
            5'd23: days = 10'd703;
            5'd24: days = 10'd734;
            5'd25: days = 10'd765;
            5'd26: days = 10'd795;
            5'd27: days = 10'd826;
            5'd28: days = 10'd856;
            5'd29: days = 10'd887;
            5'd30: days = 10'd918;
            5'd31: days = 10'd948;
        endcase
        return days;
    endfunction

    // smallest day count that reaches month index k
    function automatic logic [9:0] month_start_ceil(input int k);
        return 10'((306001 * k + 9999) / 10000);
    endfunction

endpackage

@@ rtl/cjdc_cdiv.sv @@
// ----------------------------------------------------------------------------
// cjdc_cdiv
// Pipelined floor division of a signed value by a constant, BPS quotient bits
// per stage, restoring recurrence, side data carried along with each transfer.
// ----------------------------------------------------------------------------
module cjdc_cdiv #(
    parameter int DW      = 27,
    parameter int DIVISOR = 36525,
    parameter int SW      = 8,
    parameter int BPS     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DW-1:0] in_dividend,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] out_quotient,
    output logic [SW-1:0]        out_side
);

    localparam int NST = (DW + BPS - 1) / BPS;
    localparam int AW  = NST * BPS;
    localparam int RB  = $clog2(DIVISOR) + 1;
    localparam logic [RB-1:0] DIV_C = RB'(DIVISOR);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] neg_reg;
    logic [AW-1:0]  acc_reg  [NST];
    logic [RB-1:0]  rem_reg  [NST];
    logic [SW-1:0]  side_reg [NST];
    logic [AW-1:0]  acc_next [NST];
    logic [RB-1:0]  rem_next [NST];
    logic [NST:0]   adv;
    logic [DW-1:0]  mag;

    // floor division of a negative value: divide its complement, complement back
    assign mag = in_dividend[DW-1] ? ~in_dividend : in_dividend;

    assign adv[NST] = out_ready;

    for (genvar i = 0; i < NST; i++) begin : g_stage
        logic [AW-1:0] acc_src;
        logic [RB-1:0] rem_src;

        if (i == 0) begin : g_first
            assign acc_src = AW'(mag);
            assign rem_src = '0;
        end else begin : g_rest
            assign acc_src = acc_reg[i-1];
            assign rem_src = rem_reg[i-1];
        end

        assign adv[i] = !v_reg[i] || adv[i+1];

        // BPS restoring steps
        always_comb begin
            logic [AW-1:0] acc_w;
            logic [RB-1:0] rem_w;
            acc_w = acc_src;
            rem_w = rem_src;
            for (int b = 0; b < BPS; b++) begin
                rem_w = {rem_w[RB-2:0], acc_w[AW-1]};
                acc_w = {acc_w[AW-2:0], 1'b0};
                if (rem_w >= DIV_C) begin
                    rem_w    = rem_w - DIV_C;
                    acc_w[0] = 1'b1;
                end
            end
            acc_next[i] = acc_w;
            rem_next[i] = rem_w;
        end

        // stage valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                if (i == 0) begin
                    v_reg[i] <= in_valid;
                end else begin
                    v_reg[i] <= v_reg[(i == 0) ? 0 : i-1];
                end
            end
        end

        // stage payload
        always_ff @(posedge aclk) begin
            if (adv[i]) begin
                acc_reg[i] <= acc_next[i];
                rem_reg[i] <= rem_next[i];
                if (i == 0) begin
                    neg_reg[i]  <= in_dividend[DW-1];
                    side_reg[i] <= in_side;
                end else begin
                    neg_reg[i]  <= neg_reg[(i == 0) ? 0 : i-1];
                    side_reg[i] <= side_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign in_ready     = adv[0];
    assign out_valid    = v_reg[NST-1];
    assign out_side     = side_reg[NST-1];
    assign out_quotient = neg_reg[NST-1] ? ~acc_reg[NST-1][DW-1:0]
                                         : acc_reg[NST-1][DW-1:0];

endmodule

@@ rtl/calendar_julian_day_convert.sv @@
// ----------------------------------------------------------------------------
// calendar_julian_day_convert
// Calendar date to Julian day and Julian day to calendar date, Gregorian or
// Julian calendar, fixed-point Julian days.
// ----------------------------------------------------------------------------
// One transfer enters per cycle and one result leaves per cycle while the
// receiver holds m_ready high. Each transfer passes through the registered
// stages and three constant dividers (two by 36525 for the century
// correction, one by 7305 for the year), each retiring four quotient bits per
// stage. Both commands run the same path; a date is turned into a Julian day
// and then back again to check it, a Julian day is turned into a date.
module calendar_julian_day_convert #(
    parameter int FRACTION_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [14:0] s_year,
    input  logic [3:0]         s_month,
    input  logic [4:0]         s_day,
    input  logic [31:0]        s_time_of_day,
    input  logic               s_gregorian,
    input  logic signed [56:0] s_jd_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [56:0] m_jd_out,
    output logic signed [14:0] m_year_out,
    output logic [3:0]         m_month_out,
    output logic [4:0]         m_day_out,
    output logic [31:0]        m_time_out,
    output logic               m_valid_res
);

`include "calendar_julian_day_convert_assert.svh"

    localparam int F    = FRACTION_BITS;
    localparam int IW   = 58 - F;
    localparam int W0W  = IW + 1;
    localparam int V1W  = IW + 2;
    localparam int N2W  = IW + 3;
    localparam int D3W  = N2W + 6;
    localparam int YPW  = D3W + 11;
    localparam int AW   = 27;
    localparam int DAYW = 28;
    localparam int NP   = 9;
    localparam int RW   = cjdc_pkg::R_W;

    localparam logic signed [57:0]     HALF58   = 58'(1) << (F - 1);
    localparam logic signed [IW-1:0]   SWITCH_J = IW'(cjdc_pkg::GREG_SWITCH_DAY);

    typedef struct packed {
        logic                   cmd;
        logic signed [14:0]     year;
        logic [3:0]             month;
        logic [4:0]             day;
        logic                   greg;
        logic [31:0]            tod;
        logic signed [56:0]     jd_in;
        logic signed [15:0]     u;
        logic [8:0]             mdb;
        logic signed [AW-1:0]   a;
        logic signed [15:0]     q100;
        logic signed [DAYW-1:0] days;
        logic [56:0]            jd;
        logic signed [IW-1:0]   jint;
        logic [F-1:0]           frac;
        logic signed [W0W-1:0]  w0;
        logic                   post_switch;
        logic signed [V1W-1:0]  v1;
        logic signed [N2W-1:0]  n2;
        logic [RW-1:0]          r;
        logic signed [D3W-1:0]  y0;
        logic [cjdc_pkg::N4_W-1:0] n4;
    } pl_t;

    pl_t         st_reg  [NP];
    pl_t         st_next [NP];
    logic [NP:0] v_reg;
    logic [NP:0] adv;
    logic [NP:0] src_valid;
    logic [NP:0] dst_ready;

    logic                  d1_in_ready, d1_out_valid;
    logic                  d2_in_ready, d2_out_valid;
    logic                  d3_in_ready, d3_out_valid;
    logic signed [W0W-1:0] q1;
    logic signed [V1W-1:0] q2;
    logic signed [D3W-1:0] n3;
    logic signed [D3W-1:0] dv3;
    pl_t                   d1_side, d2_side, d3_side;

    logic signed [56:0] jd_out_reg,   jd_out_next;
    logic signed [14:0] year_out_reg, year_out_next;
    logic [3:0]         month_out_reg, month_out_next;
    logic [4:0]         day_out_reg,  day_out_next;
    logic [31:0]        time_out_reg, time_out_next;
    logic               valid_res_reg, valid_res_next;

    // ------------------------------------------------------------------
    // handshake chain
    // ------------------------------------------------------------------
    assign src_valid[0] = s_valid;
    assign src_valid[1] = v_reg[0];
    assign src_valid[2] = v_reg[1];
    assign src_valid[3] = v_reg[2];
    assign src_valid[4] = v_reg[3];
    assign src_valid[5] = d1_out_valid;
    assign src_valid[6] = d2_out_valid;
    assign src_valid[7] = d3_out_valid;
    assign src_valid[8] = v_reg[7];
    assign src_valid[9] = v_reg[8];

    assign dst_ready[0] = adv[1];
    assign dst_ready[1] = adv[2];
    assign dst_ready[2] = adv[3];
    assign dst_ready[3] = adv[4];
    assign dst_ready[4] = d1_in_ready;
    assign dst_ready[5] = d2_in_ready;
    assign dst_ready[6] = d3_in_ready;
    assign dst_ready[7] = adv[8];
    assign dst_ready[8] = adv[9];
    assign dst_ready[9] = m_ready;

    assign adv = ~v_reg | dst_ready;

    // ------------------------------------------------------------------
    // date side: month shift and year split
    // ------------------------------------------------------------------
    always_comb begin
        st_next[0]       = '0;
        st_next[0].cmd   = s_cmd;
        st_next[0].year  = s_year;
        st_next[0].month = s_month;
        st_next[0].day   = s_day;
        st_next[0].greg  = s_gregorian;
        st_next[0].tod   = s_time_of_day;
        st_next[0].jd_in = s_jd_in;
        st_next[0].u     = 16'(s_year)
                         - ((s_month < 4'(cjdc_pkg::MONTH_MARCH)) ? 16'sd1 : 16'sd0);
        st_next[0].mdb   = cjdc_pkg::month_days_before(s_month);
    end

    // year days and century count
    always_comb begin
        logic signed [16:0] ab;
        logic signed [27:0] pr;
        logic [14:0]        x;
        logic [30:0]        qm;
        logic [8:0]         q;
        st_next[1] = st_reg[0];
        ab = 17'(st_reg[0].u) + 17'(cjdc_pkg::YEAR_BASE);
        pr = 28'(ab) * 28'sd1461;
        st_next[1].a = AW'(pr >>> 2);
        x  = st_reg[0].u[15] ? ~st_reg[0].u[14:0] : st_reg[0].u[14:0];
        qm = 31'(x) * 31'(cjdc_pkg::DIV100_MULT);
        q  = qm[30:cjdc_pkg::DIV100_SHIFT];
        st_next[1].q100 = st_reg[0].u[15] ? ~16'(q) : 16'(q);
    end

    // day count
    always_comb begin
        logic signed [15:0]     corr;
        logic signed [DAYW-1:0] sum;
        st_next[2] = st_reg[1];
        corr = st_reg[1].q100 - (st_reg[1].q100 >>> 2) - 16'sd2;
        sum  = DAYW'(st_reg[1].a) + DAYW'(st_reg[1].mdb) + DAYW'(st_reg[1].day)
             - DAYW'(64);
        if (st_reg[1].greg) begin
            sum = sum - DAYW'(corr);
        end
        st_next[2].days = sum;
    end

    // fixed-point Julian day and its whole day count
    always_comb begin
        logic signed [57:0] jd58;
        logic signed [57:0] jh;
        logic [31:0]        tsh;
        st_next[3] = st_reg[2];
        tsh  = st_reg[2].tod >> (32 - F);
        jd58 = (58'(st_reg[2].days) <<< F) + HALF58 + 58'(tsh);
        jh   = 58'(st_reg[2].jd_in) + HALF58;
        if (st_reg[2].cmd == cjdc_pkg::CMD_TO_JD) begin
            st_next[3].jd   = jd58[56:0];
            st_next[3].jint = IW'(st_reg[2].days) + IW'(1);
            st_next[3].frac = F'(tsh);
        end else begin
            st_next[3].jd   = '0;
            st_next[3].jint = jh[57:F];
            st_next[3].frac = jh[F-1:0];
        end
    end

    // epoch shift and reform switch test
    always_comb begin
        st_next[4] = st_reg[3];
        st_next[4].w0 = W0W'(st_reg[3].jint) + W0W'(cjdc_pkg::DAY_EPOCH);
        st_next[4].post_switch = (st_reg[3].jint >= SWITCH_J);
    end

    cjdc_cdiv #(
        .DW(W0W), .DIVISOR(cjdc_pkg::CENTURY_DAYS), .SW($bits(pl_t)), .BPS(4)
    ) u_div_c1 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v_reg[4]), .in_ready(d1_in_ready),
        .in_dividend(st_reg[4].w0), .in_side(st_reg[4]),
        .out_valid(d1_out_valid), .out_ready(adv[5]),
        .out_quotient(q1), .out_side(d1_side)
    );

    // first century estimate
    always_comb begin
        st_next[5] = d1_side;
        st_next[5].v1 = V1W'(d1_side.w0) + V1W'(q1) - V1W'(q1 >>> 2)
                      - V1W'(cjdc_pkg::CENTURY_BIAS) + V1W'(d1_side.post_switch);
    end

    cjdc_cdiv #(
        .DW(V1W), .DIVISOR(cjdc_pkg::CENTURY_DAYS), .SW($bits(pl_t)), .BPS(4)
    ) u_div_c2 (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v_reg[5]), .in_ready(d2_in_ready),
        .in_dividend(st_reg[5].v1), .in_side(st_reg[5]),
        .out_valid(d2_out_valid), .out_ready(adv[6]),
        .out_quotient(q2), .out_side(d2_side)
    );

    // corrected day count
    always_comb begin
        st_next[6] = d2_side;
        if (d2_side.greg) begin
            st_next[6].n2 = N2W'(d2_side.w0) + N2W'(q2) - N2W'(q2 >>> 2)
                          + N2W'(123 - cjdc_pkg::CENTURY_BIAS);
        end else begin
            st_next[6].n2 = N2W'(d2_side.w0) + N2W'(123);
        end
    end

    // year count
    assign dv3 = (D3W'(st_reg[6].n2) <<< 4) + (D3W'(st_reg[6].n2) <<< 2) - D3W'(2444);

    cjdc_cdiv #(
        .DW(D3W), .DIVISOR(7305), .SW($bits(pl_t)), .BPS(4)
    ) u_div_yr (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v_reg[6]), .in_ready(d3_in_ready),
        .in_dividend(dv3), .in_side(st_reg[6]),
        .out_valid(d3_out_valid), .out_ready(adv[7]),
        .out_quotient(n3), .out_side(d3_side)
    );

    // day of year
    always_comb begin
        logic signed [YPW-1:0] yp;
        logic signed [YPW-1:0] rr;
        st_next[7] = d3_side;
        yp = YPW'(n3) * YPW'(1461);
        rr = YPW'(d3_side.n2) - (yp >>> 2);
        st_next[7].r  = rr[RW-1:0];
        st_next[7].y0 = n3 - D3W'(cjdc_pkg::YEAR_OFFSET);
    end

    // month index from day of year
    always_comb begin
        st_next[8] = st_reg[7];
        st_next[8].n4 = '0;
        for (int k = 1; k <= cjdc_pkg::N4_MAX; k++) begin
            if (st_reg[7].r >= RW'(cjdc_pkg::month_start_ceil(k))) begin
                st_next[8].n4 = cjdc_pkg::N4_W'(k);
            end
        end
    end

    // result fields and round-trip check
    always_comb begin
        logic signed [5:0]     mon;
        logic signed [1:0]     yadj;
        logic signed [D3W-1:0] y;
        logic signed [RW+1:0]  d;
        logic                  ok;
        mon = $signed({1'b0, st_reg[8].n4}) - 6'sd1;
        if (mon > 6'sd12) begin
            mon = mon - 6'sd12;
        end
        if (st_reg[8].n4 < 5'd2) begin
            yadj = -2'sd1;
        end else if (st_reg[8].n4 >= 5'd14) begin
            yadj = 2'sd1;
        end else begin
            yadj = 2'sd0;
        end
        y  = st_reg[8].y0 + D3W'(yadj);
        d  = $signed({2'b00, st_reg[8].r})
           - $signed({2'b00, cjdc_pkg::month_start_floor(st_reg[8].n4)});
        ok = (y == D3W'(st_reg[8].year))
          && (mon == $signed({2'b00, st_reg[8].month}))
          && (d == $signed({7'b0, st_reg[8].day}));
        jd_out_next    = '0;
        year_out_next  = '0;
        month_out_next = '0;
        day_out_next   = '0;
        time_out_next  = '0;
        valid_res_next = 1'b0;
        if (st_reg[8].cmd == cjdc_pkg::CMD_TO_JD) begin
            jd_out_next    = st_reg[8].jd;
            valid_res_next = ok;
        end else begin
            year_out_next  = y[14:0];
            month_out_next = mon[3:0];
            day_out_next   = d[4:0];
            time_out_next  = 32'(st_reg[8].frac) << (32 - F);
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i <= NP; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= src_valid[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NP; i++) begin
            if (adv[i] && src_valid[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
        if (adv[NP] && src_valid[NP]) begin
            jd_out_reg    <= jd_out_next;
            year_out_reg  <= year_out_next;
            month_out_reg <= month_out_next;
            day_out_reg   <= day_out_next;
            time_out_reg  <= time_out_next;
            valid_res_reg <= valid_res_next;
        end
    end

    assign s_ready     = adv[0];
    assign m_valid     = v_reg[NP];
    assign m_jd_out    = jd_out_reg;
    assign m_year_out  = year_out_reg;
    assign m_month_out = month_out_reg;
    assign m_day_out   = day_out_reg;
    assign m_time_out  = time_out_reg;
    assign m_valid_res = valid_res_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CJDC_ASSERT_IMPLIES(a_doy_range, v_reg[8],
        (st_reg[8].r >= 10'd122) && (st_reg[8].r <= 10'd489),
        "day of year out of range after year division")
    `CJDC_ASSERT_IMPLIES(a_month_range, m_valid && (m_month_out != 4'd0),
        (m_month_out <= 4'd12) && (m_day_out != 5'd0),
        "date result month or day out of range")
    `CJDC_ASSERT_IMPLIES(a_jd_fields_clear, m_valid && m_valid_res,
        (m_month_out == 4'd0) && (m_day_out == 5'd0) && (m_time_out == 32'd0),
        "date fields set on a Julian day result")
    `CJDC_ASSERT_NEXT(a_entry_lands, s_valid && s_ready, v_reg[0],
        "accepted transfer missing from first stage")

endmodule

@@ bench/calendar_julian_day_convert_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Julian day converter checker
// Watches both channels, predicts every result from each accepted input
// transfer and compares it field by field with the result transfers.
// ----------------------------------------------------------------------------
module calendar_julian_day_convert_check (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [14:0] s_year,
    input  logic [3:0]         s_month,
    input  logic [4:0]         s_day,
    input  logic [31:0]        s_time_of_day,
    input  logic               s_gregorian,
    input  logic signed [56:0] s_jd_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [56:0] m_jd_out,
    input  logic signed [14:0] m_year_out,
    input  logic [3:0]         m_month_out,
    input  logic [4:0]         m_day_out,
    input  logic [31:0]        m_time_out,
    input  logic               m_valid_res,
    output int                 fail_count,
    output int                 pending,
    output int                 bad_dates
);

    localparam int FB = 32;
    localparam longint ONE_DAY = longint'(1) <<< FB;
    localparam longint HALF_DAY = longint'(1) <<< (FB - 1);

    typedef struct packed {
        logic [56:0] jd;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] tod;
        logic        ok;
    } conv_result_t;

    conv_result_t result_q[$];

    // floor division
    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Julian day to calendar date
    function automatic void jd_split(input longint jd, input logic greg,
                                     output longint y, output longint m,
                                     output longint d, output longint frac);
        longint v0, v1, n2, n3, n4, yd;
        v0 = jd + 32082 * ONE_DAY + HALF_DAY;
        if (greg) begin
            v1 = v0 + (floor_div(v0, 36525 * ONE_DAY) - floor_div(v0, 146100 * ONE_DAY)
                       - 38) * ONE_DAY;
            if (jd >= 1830691 * ONE_DAY + HALF_DAY) begin
                v1 = v1 + ONE_DAY;
            end
            v0 = v0 + (floor_div(v1, 36525 * ONE_DAY) - floor_div(v1, 146100 * ONE_DAY)
                       - 38) * ONE_DAY;
        end
        n2 = floor_div(v0, ONE_DAY) + 123;
        n3 = floor_div(20 * n2 - 2444, 7305);
        yd = floor_div(1461 * n3, 4);
        n4 = floor_div((n2 - yd) * 10000, 306001);
        m = n4 - 1;
        if (m > 12) begin
            m = m - 12;
        end
        d = n2 - yd - floor_div(306001 * n4, 10000);
        y = n3 + floor_div(n4 - 2, 12) - 4800;
        frac = (jd + HALF_DAY) & (ONE_DAY - 1);
    endfunction

    // calendar date to Julian day
    function automatic longint date_join(input longint y, input longint m, input longint d,
                                         input longint t, input logic greg);
        longint u, u1, days;
        u = y - ((m < 3) ? 1 : 0);
        u1 = m + 1;
        if (u1 < 4) begin
            u1 = u1 + 12;
        end
        days = floor_div((u + 4712) * 1461, 4) + (306 * u1) / 10 + d - 64;
        if (greg) begin
            days = days - (floor_div(u, 100) - floor_div(u, 400)) + 2;
        end
        return days * ONE_DAY + HALF_DAY + (t >>> (32 - FB));
    endfunction

    function automatic conv_result_t predict_conversion();
        conv_result_t r;
        longint y, m, d, jd, ry, rm, rd, rf;
        r = '0;
        y = longint'(s_year);
        m = longint'(s_month);
        d = longint'(s_day);
        if (s_cmd == cjdc_pkg::CMD_TO_JD) begin
            jd = date_join(y, m, d, longint'(s_time_of_day), s_gregorian);
            jd_split(jd, s_gregorian, ry, rm, rd, rf);
            r.jd = jd[56:0];
            r.ok = (ry == y && rm == m && rd == d);
        end else begin
            jd = longint'(s_jd_in);
            jd_split(jd, s_gregorian, ry, rm, rd, rf);
            r.year = ry[14:0];
            r.month = rm[3:0];
            r.day = rd[4:0];
            r.tod = rf[31:0];
        end
        return r;
    endfunction

    assign pending = result_q.size();

    // predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        conv_result_t exp_r;
        if (!aresetn) begin
            fail_count <= 0;
            bad_dates <= 0;
        end else begin
            if (s_valid && s_ready) begin
                exp_r = predict_conversion();
                result_q.push_back(exp_r);
                if (s_cmd == cjdc_pkg::CMD_TO_JD && !exp_r.ok) begin
                    bad_dates <= bad_dates + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_jd_out !== exp_r.jd || m_year_out !== exp_r.year ||
                        m_month_out !== exp_r.month || m_day_out !== exp_r.day ||
                        m_time_out !== exp_r.tod || m_valid_res !== exp_r.ok) begin
                        fail_count <= fail_count + 1;
                    end
                    if (m_jd_out !== exp_r.jd)
                        $error("jd_out: expected %h, got %h", exp_r.jd, m_jd_out);
                    if (m_year_out !== exp_r.year)
                        $error("year_out: expected %h, got %h", exp_r.year, m_year_out);
                    if (m_month_out !== exp_r.month)
                        $error("month_out: expected %h, got %h", exp_r.month, m_month_out);
                    if (m_day_out !== exp_r.day)
                        $error("day_out: expected %h, got %h", exp_r.day, m_day_out);
                    if (m_time_out !== exp_r.tod)
                        $error("time_out: expected %h, got %h", exp_r.tod, m_time_out);
                    if (m_valid_res !== exp_r.ok)
                        $error("valid_res: expected %b, got %b", exp_r.ok, m_valid_res);
                end
            end
        end
    end

endmodule

@@ bench/calendar_julian_day_convert_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Julian day converter testbench
// Drives directed and random conversions in both directions and calendars,
// with bursty input, a patterned stalling receiver and a long output hold.
// ----------------------------------------------------------------------------
module calendar_julian_day_convert_tb;

    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 80;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic signed [14:0] s_year;
    logic [3:0]         s_month;
    logic [4:0]         s_day;
    logic [31:0]        s_time_of_day;
    logic               s_gregorian;
    logic signed [56:0] s_jd_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [56:0] m_jd_out;
    logic signed [14:0] m_year_out;
    logic [3:0]         m_month_out;
    logic [4:0]         m_day_out;
    logic [31:0]        m_time_out;
    logic               m_valid_res;
    int                 fail_count;
    int                 pending;
    int                 bad_dates;
    int                 burst_left;
    int                 to_jd_count;
    int                 to_date_count;
    bit                 hold_go;

    calendar_julian_day_convert i_dut (.*);

    calendar_julian_day_convert_check i_check (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // receiver: ready until the dense stretch starts, a long hold there,
    // then a series of randomly picked stall patterns
    initial begin
        int mode;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        m_ready <= 1'b1;
        wait (hold_go);
        @(posedge aclk);
        for (int i = 0; i < 200; i++) begin
            m_ready <= 1'b0;
            @(posedge aclk);
        end
        forever begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 64; i++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= (i % 5) != 0;
                endcase
                @(posedge aclk);
            end
        end
    end

    // one input transfer; gaps fall between bursts unless dense is set
    task automatic send_item(input logic cmd, input logic [14:0] yr, input logic [3:0] mo,
                             input logic [4:0] dy, input logic [31:0] tod,
                             input logic greg, input logic [56:0] jd, input bit dense);
        logic rdy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!dense) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_year <= yr;
        s_month <= mo;
        s_day <= dy;
        s_time_of_day <= tod;
        s_gregorian <= greg;
        s_jd_in <= jd;
        if (cmd == cjdc_pkg::CMD_TO_JD) to_jd_count++;
        else to_date_count++;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    task automatic send_date(input int yr, input int mo, input int dy,
                             input logic [31:0] tod, input logic greg);
        send_item(cjdc_pkg::CMD_TO_JD, 15'(yr), 4'(mo), 5'(dy), tod, greg,
                  57'($urandom), 1'b0);
    endtask

    task automatic send_jd(input longint jd, input logic greg);
        send_item(cjdc_pkg::CMD_TO_DATE, 15'($urandom), 4'($urandom), 5'($urandom),
                  $urandom, greg, jd[56:0], 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        longint jd;
        logic [63:0] rnd;
        int kind;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = cjdc_pkg::CMD_TO_JD;
        s_year = '0;
        s_month = '0;
        s_day = '0;
        s_time_of_day = '0;
        s_gregorian = 1'b0;
        s_jd_in = '0;
        burst_left = 0;
        to_jd_count = 0;
        to_date_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, calendar switch, negative centuries, bad dates
        send_date(-4800, 1, 1, 32'h0, 1'b1);
        send_date(9999, 12, 31, 32'hFFFF_FFFF, 1'b1);
        send_date(-16384, 15, 31, 32'h8000_0000, 1'b0);
        send_date(16383, 0, 0, 32'h0, 1'b1);
        send_date(2000, 1, 32 - 1, 32'h1234_5678, 1'b1);
        send_date(2001, 2, 29, 32'h0, 1'b1);
        send_date(1900, 2, 29, 32'h0, 1'b0);
        send_date(1900, 2, 29, 32'h0, 1'b1);
        send_date(1582, 10, 15, 32'h0, 1'b1);
        send_date(1582, 10, 4, 32'h0, 1'b0);
        send_date(-100, 3, 1, 32'h0, 1'b1);
        send_date(-400, 2, 29, 32'h0, 1'b1);
        send_date(-4713, 1, 1, 32'h8000_0000, 1'b0);
        send_date(2024, 13, 5, 32'h0, 1'b1);
        send_date(2024, 4, 31, 32'h0, 1'b1);
        send_jd(0, 1'b0);
        send_jd(longint'(2299160) <<< 32 | 64'h8000_0000, 1'b1);
        send_jd(longint'(1830691) <<< 32 | 64'h8000_0000, 1'b1);
        send_jd(longint'(1830691) <<< 32 | 64'h7FFF_FFFF, 1'b1);
        send_jd(-(longint'(1) <<< 56), 1'b1);
        send_jd((longint'(1) <<< 56) - 1, 1'b0);
        send_jd(-1, 1'b1);
        send_jd(longint'(2451545) <<< 32, 1'b1);

        // sender pauses until every result is back
        wait_drained();

        // random part; a dense stretch early overlaps the long receiver hold
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 9);
            rnd = {$urandom, $urandom};
            if (n == 41) hold_go = 1'b1;
            if (n < 300 && n > 40) begin
                send_item(kind[0], 15'($urandom_range(0, 14799) - 4800),
                          4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)),
                          $urandom, 1'($urandom_range(0, 1)), rnd[56:0], 1'b1);
            end else if (kind < 4) begin
                send_date($urandom_range(0, 14799) - 4800, $urandom_range(1, 12),
                          $urandom_range(1, 31), $urandom, 1'($urandom_range(0, 1)));
            end else if (kind < 5) begin
                send_item(cjdc_pkg::CMD_TO_JD, rnd[14:0], rnd[18:15], rnd[23:19],
                          rnd[63:32], rnd[24], rnd[56:0], 1'b0);
            end else if (kind < 8) begin
                jd = (longint'($urandom_range(0, 5400000)) - 100000) <<< 32;
                send_jd(jd | longint'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                send_jd(longint'(rnd), rnd[60]);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d date-to-day and %0d day-to-date conversions,",
                 to_jd_count, to_date_count);
        $display("%0d of the dates flagged as not round-tripping.", bad_dates);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
